// File: rtl/tte_pkg.sv
// Shared types and constants for the tap tempo beat envelope block.
// Holds the payload structs, register map codes and reset values.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package tte_pkg;

  // Default width of the tick counters and the beat period.
  localparam int TTE_TIME_WIDTH = 24;

  // Envelope fraction bits; the envelope is unsigned Q1.LEVEL_FRAC.
  localparam int LEVEL_FRAC = 16;
  localparam int LEVEL_W    = LEVEL_FRAC + 1;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC{1'b0}}};

  // Configuration register widths and reset values.
  localparam int TIMEOUT_W = 24;
  localparam int DECAY_W   = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd3000;
  localparam logic [DECAY_W-1:0]   DECAY_RST   = 16'd62259;

  // Beat period after reset: 500 ticks, which is 120 bpm.
  localparam int START_PERIOD = 500;

  // Configuration port geometry and register indexes (byte address bit 2).
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_DECAY   = 1'b1;

  // Tap measurement phase: idle, or the number of taps taken so far.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ONE   = 4'b0010,
    PH_TWO   = 4'b0100,
    PH_THREE = 4'b1000
  } tap_phase_t;

  typedef struct packed {
    logic tap;
    logic frame;
  } tte_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               beat_fired;
  } tte_out_t;

endpackage

// File: rtl/tte_tap_meter.sv
// Tap interval measurement: tap phase sequencer, span and gap counters,
// and the beat period register. Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_tap_meter
  import tte_pkg::*;
#(
  parameter int TIME_WIDTH = TTE_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  tap,
  input  logic [TIMEOUT_W-1:0]  timeout,
  output logic [TIME_WIDTH-1:0] period_nxt
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam int CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

  tap_phase_t            phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] span_r, span_nxt, span_inc;
  logic [TIME_WIDTH-1:0] gap_r, gap_nxt, gap_inc;
  // The span divided by three is kept as a running quotient and remainder.
  logic [TIME_WIDTH-1:0] quot_r, quot_nxt, quot_inc;
  logic [1:0]            rem_r, rem_nxt, rem_inc;
  logic [TIME_WIDTH-1:0] period_r;
  logic                  active;
  logic                  late;

  always_comb begin
    active   = (phase_r != PH_IDLE);
    span_inc = span_r;
    gap_inc  = gap_r;
    quot_inc = quot_r;
    rem_inc  = rem_r;
    if (active) begin
      if (span_r != TIME_MAX) begin
        span_inc = span_r + 1'b1;
        if (rem_r == 2'd2) begin
          quot_inc = quot_r + 1'b1;
          rem_inc  = 2'd0;
        end else begin
          rem_inc = rem_r + 1'b1;
        end
      end
      if (gap_r != TIME_MAX) begin
        gap_inc = gap_r + 1'b1;
      end
    end

    late = CMP_W'(gap_inc) >= CMP_W'(timeout);

    phase_nxt  = phase_r;
    span_nxt   = span_inc;
    gap_nxt    = gap_inc;
    quot_nxt   = quot_inc;
    rem_nxt    = rem_inc;
    period_nxt = period_r;

    if (tap) begin
      case (phase_r)
        PH_IDLE: begin
          phase_nxt = PH_ONE;
          span_nxt  = '0;
          gap_nxt   = '0;
          quot_nxt  = '0;
          rem_nxt   = 2'd0;
        end
        PH_ONE, PH_TWO: begin
          if (late) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = (phase_r == PH_ONE) ? PH_TWO : PH_THREE;
            gap_nxt   = '0;
          end
        end
        PH_THREE: begin
          // The fourth tap in time closes the measurement.
          if (!late) begin
            period_nxt = quot_inc;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      span_r   <= '0;
      gap_r    <= '0;
      quot_r   <= '0;
      rem_r    <= 2'd0;
      period_r <= TIME_WIDTH'(START_PERIOD);
    end else if (step) begin
      phase_r  <= phase_nxt;
      span_r   <= span_nxt;
      gap_r    <= gap_nxt;
      quot_r   <= quot_nxt;
      rem_r    <= rem_nxt;
      period_r <= period_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != 2'd3)
    else $error("span remainder out of range");

  a_period_from_third: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(period_r) |-> $past(phase_r) == PH_THREE)
    else $error("beat period changed outside the fourth tap");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && tap && phase_r == PH_IDLE |=> phase_r == PH_ONE && span_r == '0
      && gap_r == '0)
    else $error("starting tap did not open a measurement");
`endif

endmodule

// File: rtl/tap_tempo_beat_envelope_core.sv
// Top level of the tap tempo beat envelope block: request channels,
// configuration registers, envelope decay and beat check.
// Depends on tte_pkg and tte_tap_meter.
`timescale 1ns / 1ps

// One input request is one 1 ms tick carrying a tap flag and a frame
// strobe. The block takes one request per clock cycle while in_stall
// is low; a frame request produces one result in the next cycle, and
// other requests produce none. in_stall is high only while a result
// sits in the output register and out_stall holds it, so the output
// register alone sets back-pressure. The longest path is the 17x16
// envelope decay multiply. The beat period is the span of four taps
// divided by three as a running quotient, so no divider is involved.
module tap_tempo_beat_envelope_core
  import tte_pkg::*;
#(
  parameter int TIME_WIDTH = TTE_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tte_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tte_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam int PROD_W = LEVEL_W + DECAY_W;

  logic [TIMEOUT_W-1:0]  timeout_r;
  logic [DECAY_W-1:0]    decay_r;
  logic [TIME_WIDTH-1:0] since_r, since_nxt, since_inc;
  logic [LEVEL_W-1:0]    env_r, env_nxt, env_dec;
  logic                  out_valid_r, out_valid_nxt;
  tte_out_t              out_data_r, out_data_nxt;
  logic [PROD_W-1:0]     prod;
  logic [TIME_WIDTH-1:0] period_nxt;
  logic                  in_acc;
  logic                  fire;
  logic                  cfg_wr;

  assign in_stall   = out_valid_r && out_stall;
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  tte_tap_meter #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_tap_meter (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .tap       (in_data.tap),
    .timeout   (timeout_r),
    .period_nxt(period_nxt)
  );

  always_comb begin
    case (cfg_paddr[2])
      REG_TIMEOUT: cfg_prdata = CFG_DATA_W'(timeout_r);
      REG_DECAY:   cfg_prdata = CFG_DATA_W'(decay_r);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      decay_r   <= DECAY_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_TIMEOUT: timeout_r <= cfg_pwdata[TIMEOUT_W-1:0];
        REG_DECAY:   decay_r   <= cfg_pwdata[DECAY_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    since_inc = (since_r == TIME_MAX) ? since_r : since_r + 1'b1;
    prod      = PROD_W'(env_r) * PROD_W'(decay_r);
    env_dec   = prod[PROD_W-1:DECAY_W];
    // The beat check sees the period as updated by a tap in the same tick.
    fire      = since_inc > period_nxt;

    since_nxt     = since_r;
    env_nxt       = env_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (in_acc) begin
      since_nxt = since_inc;
      if (in_data.frame) begin
        if (fire) begin
          since_nxt = '0;
          env_nxt   = LEVEL_ONE;
        end else begin
          env_nxt = env_dec;
        end
        out_valid_nxt           = 1'b1;
        out_data_nxt.level      = fire ? LEVEL_ONE : env_dec;
        out_data_nxt.beat_fired = fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r     <= '0;
      env_r       <= LEVEL_ONE;
      out_valid_r <= 1'b0;
    end else begin
      since_r     <= since_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_fire_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.beat_fired |-> out_data_r.level == LEVEL_ONE)
    else $error("beat fired without a full envelope");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.level <= LEVEL_ONE)
    else $error("envelope above 1.0");

  a_result_per_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r == $past(in_data.frame))
    else $error("result presence does not follow the frame strobe");
`endif

endmodule

// File: sim/tap_tempo_beat_envelope_core_test.sv
// Self-checking testbench for tap_tempo_beat_envelope_core: directed ticks, then random tap
// and frame requests under several register settings, checked against an in-bench predictor.
// Depends on tte_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tap_tempo_beat_envelope_core_test;
  import tte_pkg::*;

  localparam int TW = TTE_TIME_WIDTH;
  localparam int IDLE_LIMIT = 500;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_TICKS = 150;

  typedef enum {ROW_TICK, ROW_SET_TIMEOUT, ROW_SET_DECAY} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        tap;
    logic        frame;
    bit          fixed;
    tte_out_t    res;
    logic [31:0] value;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  tte_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tte_out_t              out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tap_tempo_beat_envelope_core dut (.*);

  always #4 clk = ~clk;

  // Predictor copy of the registers and the block state.
  logic [TIMEOUT_W-1:0] tmo_ticks = TIMEOUT_RST;
  logic [DECAY_W-1:0]   decay_q16 = DECAY_RST;
  logic [TW-1:0]        period_ticks = TW'(START_PERIOD);
  logic [TW-1:0]        ticks_since_beat = '0;
  logic [TW-1:0]        span_ticks = '0;
  logic [TW-1:0]        gap_ticks = '0;
  logic [LEVEL_W-1:0]   envelope_lvl = LEVEL_ONE;
  tap_phase_t           phase = PH_IDLE;

  tte_out_t pending_levels[$];
  int       errors = 0;
  bit       tx_idling = 1'b0;
  bit       rx_idling = 1'b0;
  int       stall_left = 0;
  int       quiet_cycles = 0;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function void advance_tick(input tte_in_t d, output bit emits, output tte_out_t r);
    logic [LEVEL_W+DECAY_W-1:0] prod;
    emits = 1'b0;
    r = '0;
    ticks_since_beat = sat_inc(ticks_since_beat);
    if (phase != PH_IDLE) begin
      span_ticks = sat_inc(span_ticks);
      gap_ticks = sat_inc(gap_ticks);
    end
    if (d.tap) begin
      if (phase == PH_IDLE) begin
        phase = PH_ONE;
        span_ticks = '0;
        gap_ticks = '0;
      end else if (gap_ticks >= tmo_ticks) begin
        // A late tap cancels the measurement and is itself dropped.
        phase = PH_IDLE;
      end else if (phase == PH_THREE) begin
        period_ticks = span_ticks / TW'(3);
        phase = PH_IDLE;
      end else begin
        phase = (phase == PH_ONE) ? PH_TWO : PH_THREE;
        gap_ticks = '0;
      end
    end
    if (d.frame) begin
      prod = envelope_lvl * decay_q16;
      envelope_lvl = prod[LEVEL_W+DECAY_W-1:DECAY_W];
      if (ticks_since_beat > period_ticks) begin
        ticks_since_beat = '0;
        envelope_lvl = LEVEL_ONE;
        r.beat_fired = 1'b1;
      end
      r.level = envelope_lvl;
      emits = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tte_out_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t: result with none expected, level %0d beat %0d", $time,
                 out_data.level, out_data.beat_fired);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (out_data.level !== want.level) begin
          $display("%0t: level expected %0d got %0d", $time, want.level, out_data.level);
          errors++;
        end
        if (out_data.beat_fired !== want.beat_fired) begin
          $display("%0t: beat_fired expected %0d got %0d", $time, want.beat_fired,
                   out_data.beat_fired);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rx_idling && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  task automatic send_tick(input tte_in_t d, input bit fixed, input tte_out_t fixed_res);
    bit       emits;
    tte_out_t r;
    int       gap;
    @(negedge clk);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    advance_tick(d, emits, r);
    if (emits) pending_levels.push_back(fixed ? fixed_res : r);
  endtask

  // Ticks without a frame give no result, so a drain wait after the last result lets them settle.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    logic [31:0] kept;
    wait_quiet();
    kept = (idx == REG_TIMEOUT) ? 32'(data[TIMEOUT_W-1:0]) : 32'(data[DECAY_W-1:0]);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_TIMEOUT) tmo_ticks = data[TIMEOUT_W-1:0];
    else decay_q16 = data[DECAY_W-1:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== kept) begin
      $display("%0t: register %0d readback expected %0h got %0h", $time, idx, kept,
               cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    stim_row_t   directed_rows [21];
    tte_in_t     d;
    logic [31:0] tmo_val;
    logic [15:0] decay_val;
    int          limit;
    int          g;
    int          emitted;
    int          odds;

    directed_rows = '{
      '{ROW_TICK, 1'b0, 1'b1, 1'b1, {17'd62259, 1'b0}, 32'd0},
      // Four taps on back-to-back ticks span three ticks, so the period becomes one.
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b1, 1'b1, {17'd65536, 1'b1}, 32'd0},
      '{ROW_TICK, 1'b0, 1'b1, 1'b1, {17'd62259, 1'b0}, 32'd0},
      '{ROW_TICK, 1'b0, 1'b1, 1'b1, {17'd65536, 1'b1}, 32'd0},
      // Only high bits set: the timeout becomes zero, so each tap after a starting tap is late.
      '{ROW_SET_TIMEOUT, 1'b0, 1'b0, 1'b0, '0, 32'h0100_0000},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b1, 1'b0, '0, 32'd0},
      '{ROW_SET_TIMEOUT, 1'b0, 1'b0, 1'b0, '0, 32'd1},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b1, 1'b0, 1'b0, '0, 32'd0},
      '{ROW_SET_DECAY, 1'b0, 1'b0, 1'b0, '0, 32'hFFFF_0000},
      '{ROW_TICK, 1'b0, 1'b1, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b0, 1'b1, 1'b1, {17'd0, 1'b0}, 32'd0},
      '{ROW_SET_DECAY, 1'b0, 1'b0, 1'b0, '0, 32'd65535},
      '{ROW_TICK, 1'b0, 1'b1, 1'b0, '0, 32'd0},
      '{ROW_TICK, 1'b0, 1'b1, 1'b1, {17'd65535, 1'b0}, 32'd0}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    tx_idling = 1'b1;
    rx_idling = 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_TICK: begin
          d.tap = directed_rows[i].tap;
          d.frame = directed_rows[i].frame;
          send_tick(d, directed_rows[i].fixed, directed_rows[i].res);
        end
        ROW_SET_TIMEOUT: write_reg(REG_TIMEOUT, directed_rows[i].value);
        ROW_SET_DECAY: write_reg(REG_DECAY, directed_rows[i].value);
        default: ;
      endcase
    end

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: tmo_val = 32'h00FF_FFFF;
        1: tmo_val = 32'd1;
        2: tmo_val = 32'd0;
        3: tmo_val = $urandom_range(16, 60);
        4: tmo_val = 32'd3000;
        default: tmo_val = $urandom_range(2, 120);
      endcase
      case (p % 4)
        0: decay_val = 16'hFFFF;
        1: decay_val = 16'h0000;
        2: decay_val = DECAY_RST;
        default: decay_val = 16'($urandom);
      endcase
      write_reg(REG_TIMEOUT, {8'($urandom), tmo_val[23:0]});
      write_reg(REG_DECAY, {16'($urandom), decay_val});
      // One phase and the closing one run without any idling.
      tx_idling = (p != 4 && p != 8);
      rx_idling = (p != 4 && p != 8);
      odds = (p % 2 == 1) ? 1 : 6;
      limit = (tmo_ticks > 1 && tmo_ticks <= 41) ? int'(tmo_ticks) - 1 : 40;
      emitted = 0;
      while (emitted < PHASE_TICKS) begin
        // Mostly taps that keep a measurement going, now and then a late one.
        if (tmo_ticks >= 2 && tmo_ticks <= 200 && $urandom_range(0, 5) == 0)
          g = int'(tmo_ticks) + $urandom_range(0, 2);
        else
          g = $urandom_range(1, limit);
        for (int k = 1; k <= g; k++) begin
          d.tap = (k == g);
          d.frame = ($urandom_range(0, odds) == 0);
          send_tick(d, 1'b0, '0);
          emitted++;
          if (p == 5 && emitted == PHASE_TICKS / 2) wait_quiet();
        end
      end
    end

    wait_quiet();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
rtl/tte_pkg.sv
rtl/tte_tap_meter.sv
rtl/tap_tempo_beat_envelope_core.sv
sim/tap_tempo_beat_envelope_core_test.sv
